/* rtl/generational_handle_allocator_macros.svh */
// Assertion macros shared by the generational handle allocator RTL.
// Defining ASSERT_OFF turns every check into an empty statement.
// No other file is needed to use these macros.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define HGA_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");
// Next-cycle implication.
`define HGA_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");
`else
`define HGA_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons)
`define HGA_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

/* rtl/hga_pkg.sv */
`timescale 1ns / 1ps
// Package for the generational handle allocator: field widths, command and
// status codes, and the control bundle from controller to datapath. No dependencies.
package hga_pkg;

  localparam int CMD_W    = 2;
  localparam int HIDX_W   = 10;
  localparam int HGEN_W   = 12;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DESTROY = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_STALE    = 2'd1,
    STATUS_CAPACITY = 2'd2
  } status_t;

  // load: an item transfer happens this cycle; exec: carry out the latched item.
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_t;

endpackage

/* rtl/hga_req_if.sv */
`timescale 1ns / 1ps
// Request channel of the generational handle allocator.
// Depends on hga_pkg for the field widths and command type.
interface hga_req_if;
  import hga_pkg::*;

  logic                valid;
  logic                ready;
  cmd_t                cmd;
  logic [HIDX_W-1:0]   handle_index;
  logic [HGEN_W-1:0]   handle_generation;

  modport source (output valid, cmd, handle_index, handle_generation, input ready);
  modport sink (input valid, cmd, handle_index, handle_generation, output ready);
endinterface

/* rtl/hga_rsp_if.sv */
`timescale 1ns / 1ps
// Response channel of the generational handle allocator.
// Depends on hga_pkg for the field widths and status type.
interface hga_rsp_if;
  import hga_pkg::*;

  logic                valid;
  logic                ready;
  status_t             status;
  logic [HIDX_W-1:0]   result_index;
  logic [HGEN_W-1:0]   result_generation;
  logic                is_alive;
  logic [COUNT_W-1:0]  live_count;

  modport source (output valid, status, result_index, result_generation, is_alive,
                  live_count, input ready);
  modport sink (input valid, status, result_index, result_generation, is_alive,
                live_count, output ready);
endinterface

/* rtl/generational_handle_allocator.sv */
`timescale 1ns / 1ps
// Top level of the generational handle allocator: controller plus datapath.
// Depends on hga_pkg, hga_req_if, hga_rsp_if, hga_ctrl, hga_datapath and the macros header.
//
//   channel | direction | fields
//   --------+-----------+---------------------------------------------------------
//   req     | in        | cmd, handle_index, handle_generation
//   rsp     | out       | status, result_index, result_generation, is_alive, live_count
//
// Each item's transfer cycle issues the registered reads of the slot and free-stack
// memories; the execute step that follows evaluates the item and writes them back.
// The result register holds a finished result while a new item is read in; the
// execute step waits while that register is still full.
// Reset clears only the counters and the controller state; there is no clearing pass over the memories.
`include "generational_handle_allocator_macros.svh"

module generational_handle_allocator #(
  parameter int MAX_HANDLES = 1024,
  parameter int GEN_BITS    = 12
) (
  input logic      clk,
  input logic      rst,
  hga_req_if.sink  req,
  hga_rsp_if.source rsp
);
  import hga_pkg::*;

  ctrl_t ctrl;

  hga_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .ctrl      (ctrl)
  );

  hga_datapath #(
    .MAX_HANDLES (MAX_HANDLES),
    .GEN_BITS    (GEN_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .ctrl              (ctrl),
    .cmd               (req.cmd),
    .handle_index      (req.handle_index),
    .handle_generation (req.handle_generation),
    .status            (rsp.status),
    .result_index      (rsp.result_index),
    .result_generation (rsp.result_generation),
    .is_alive          (rsp.is_alive),
    .live_count        (rsp.live_count)
  );

  `HGA_ASSERT_IMPL(a_exec_has_room, clk, rst, ctrl.exec, !rsp.valid || rsp.ready)
  `HGA_ASSERT_NEXT(a_busy_after_load, clk, rst, ctrl.load, !req.ready)
  `HGA_ASSERT_NEXT(a_exec_shows_result, clk, rst, ctrl.exec, rsp.valid)
  `HGA_ASSERT_IMPL(a_fail_has_no_index, clk, rst, rsp.valid && (rsp.status != STATUS_OK), rsp.result_index == '0)

endmodule

/* rtl/hga_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; contents are not reset.
module hga_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/hga_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the generational handle allocator: accept, execute, and the
// result register's valid flag. Depends on hga_pkg.
module hga_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output hga_pkg::ctrl_t ctrl
);
  import hga_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;

  assign in_ready  = (state == ST_IDLE);
  assign ctrl.load = in_valid && (state == ST_IDLE);
  // The item executes only when the result register is free or drains now.
  assign ctrl.exec = (state == ST_EXEC) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (ctrl.load) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (ctrl.exec) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (ctrl.exec) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/hga_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the generational handle allocator: slot and free-stack memories,
// the counters and the result register. Depends on hga_pkg and hga_ram.
module hga_datapath #(
  parameter int MAX_HANDLES = 1024,
  parameter int GEN_BITS    = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  hga_pkg::ctrl_t                ctrl,
  input  hga_pkg::cmd_t                 cmd,
  input  logic [hga_pkg::HIDX_W-1:0]    handle_index,
  input  logic [hga_pkg::HGEN_W-1:0]    handle_generation,
  output hga_pkg::status_t              status,
  output logic [hga_pkg::HIDX_W-1:0]    result_index,
  output logic [hga_pkg::HGEN_W-1:0]    result_generation,
  output logic                          is_alive,
  output logic [hga_pkg::COUNT_W-1:0]   live_count
);
  import hga_pkg::*;

  localparam int IDX_W  = $clog2(MAX_HANDLES);
  localparam int CNT_W  = $clog2(MAX_HANDLES + 1);
  localparam int IW     = (IDX_W > HIDX_W) ? IDX_W : HIDX_W;
  localparam int XW     = (IW > CNT_W) ? IW : CNT_W;
  localparam int CMP_W  = (GEN_BITS > HGEN_W) ? GEN_BITS : HGEN_W;
  localparam int LW     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int SLOT_W = GEN_BITS + 1;
  localparam int STK_W  = IDX_W + GEN_BITS;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_HANDLES);

  // Counters.
  logic [CNT_W-1:0] free_top, free_top_next;
  logic [CNT_W-1:0] high_water, high_water_next;

  // Latched item.
  cmd_t              op;
  logic [IDX_W-1:0]  op_addr;
  logic              op_in_range;
  logic [HGEN_W-1:0] op_gen;

  // Memory ports. Slot entries are {live, generation}; stack entries are
  // {generation, index}, so a pop needs no second slot read.
  logic              slot_wr_en;
  logic [IDX_W-1:0]  slot_wr_addr;
  logic [SLOT_W-1:0] slot_wr_data;
  logic [IDX_W-1:0]  slot_rd_addr;
  logic [SLOT_W-1:0] slot_rd_data;
  logic              stk_wr_en;
  logic [IDX_W-1:0]  stk_wr_addr;
  logic [STK_W-1:0]  stk_wr_data;
  logic [IDX_W-1:0]  stk_rd_addr;
  logic [STK_W-1:0]  stk_rd_data;

  logic [IW-1:0]       in_idx_wide;
  logic [CNT_W-1:0]    top_minus_one;
  logic [GEN_BITS-1:0] slot_gen;
  logic [GEN_BITS-1:0] gen_bumped;
  logic                handle_ok;
  logic [IDX_W-1:0]    new_slot;
  logic [GEN_BITS-1:0] new_gen;
  logic [CNT_W-1:0]    live_next;

  status_t             status_next;
  logic [IDX_W-1:0]    r_idx_next;
  logic [GEN_BITS-1:0] r_gen_next;
  logic                alive_next;

  assign in_idx_wide   = IW'(handle_index);
  assign top_minus_one = free_top - CNT_W'(1);
  assign slot_rd_addr  = in_idx_wide[IDX_W-1:0];
  assign stk_rd_addr   = top_minus_one[IDX_W-1:0];

  assign slot_gen   = slot_rd_data[GEN_BITS-1:0];
  assign gen_bumped = slot_gen + GEN_BITS'(1);
  assign handle_ok  = op_in_range && slot_rd_data[GEN_BITS]
                      && (CMP_W'(slot_gen) == CMP_W'(op_gen));

  hga_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_HANDLES)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_wr_addr),
    .wr_data (slot_wr_data),
    .rd_en   (ctrl.load),
    .rd_addr (slot_rd_addr),
    .rd_data (slot_rd_data)
  );

  hga_ram #(
    .WIDTH (STK_W),
    .DEPTH (MAX_HANDLES)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (stk_wr_en),
    .wr_addr (stk_wr_addr),
    .wr_data (stk_wr_data),
    .rd_en   (ctrl.load),
    .rd_addr (stk_rd_addr),
    .rd_data (stk_rd_data)
  );

  always_comb begin
    free_top_next   = free_top;
    high_water_next = high_water;
    slot_wr_en      = 1'b0;
    slot_wr_addr    = op_addr;
    slot_wr_data    = {1'b0, gen_bumped};
    stk_wr_en       = 1'b0;
    stk_wr_addr     = free_top[IDX_W-1:0];
    stk_wr_data     = {gen_bumped, op_addr};
    status_next     = STATUS_OK;
    r_idx_next      = '0;
    r_gen_next      = '0;
    alive_next      = 1'b0;
    new_slot        = high_water[IDX_W-1:0];
    new_gen         = '0;
    unique case (op)
      CMD_CREATE: begin
        if (free_top != '0) begin
          // Reuse the most recently freed slot with its stored generation.
          new_slot      = stk_rd_data[IDX_W-1:0];
          new_gen       = stk_rd_data[STK_W-1:IDX_W];
          free_top_next = top_minus_one;
        end else if (high_water != MAX_CNT) begin
          high_water_next = high_water + CNT_W'(1);
        end
        if ((free_top != '0) || (high_water != MAX_CNT)) begin
          slot_wr_en   = 1'b1;
          slot_wr_addr = new_slot;
          slot_wr_data = {1'b1, new_gen};
          r_idx_next   = new_slot;
          r_gen_next   = new_gen;
        end else begin
          status_next = STATUS_CAPACITY;
        end
      end
      CMD_DESTROY: begin
        if (handle_ok) begin
          slot_wr_en = 1'b1;
          alive_next = 1'b1;
          if (free_top != MAX_CNT) begin
            stk_wr_en     = 1'b1;
            free_top_next = free_top + CNT_W'(1);
          end
        end else begin
          status_next = STATUS_STALE;
        end
      end
      CMD_QUERY: begin
        if (handle_ok) begin
          alive_next = 1'b1;
        end else begin
          status_next = STATUS_STALE;
        end
      end
      CMD_CLEAR: begin
        free_top_next   = '0;
        high_water_next = '0;
      end
      default: begin
        status_next = STATUS_OK;
      end
    endcase
    slot_wr_en = slot_wr_en && ctrl.exec;
    stk_wr_en  = stk_wr_en && ctrl.exec;
  end

  assign live_next = high_water_next - free_top_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      free_top   <= '0;
      high_water <= '0;
    end else if (ctrl.exec) begin
      free_top   <= free_top_next;
      high_water <= high_water_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      op          <= cmd;
      op_addr     <= in_idx_wide[IDX_W-1:0];
      op_in_range <= (XW'(handle_index) < XW'(high_water));
      op_gen      <= handle_generation;
    end
    if (ctrl.exec) begin
      status            <= status_next;
      result_index      <= HIDX_W'(IW'(r_idx_next));
      result_generation <= HGEN_W'(CMP_W'(r_gen_next));
      is_alive          <= alive_next;
      live_count        <= COUNT_W'(LW'(live_next));
    end
  end

endmodule

/* tb/sv/tb_generational_handle_allocator.sv */
`timescale 1ns / 1ps
// Self-checking testbench for generational_handle_allocator: directed table, mixed random
// traffic, fill to capacity, slot reuse at full capacity. Needs hga_pkg, hga_req_if,
// hga_rsp_if and the allocator RTL.
module tb_generational_handle_allocator;
  import hga_pkg::*;

  localparam int NUM_SLOTS   = 1024;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int SHOW_ERRORS = 10;

  typedef struct packed {
    status_t             status;
    logic [HIDX_W-1:0]   index;
    logic [HGEN_W-1:0]   generation;
    logic                alive;
    logic [COUNT_W-1:0]  count;
  } alloc_result_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [HIDX_W-1:0]   index;
    logic [HGEN_W-1:0]   generation;
    logic                typed;
    alloc_result_t       want;
  } dir_row_t;

  // Rows with typed set carry their own expected result; the others use the predictor.
  localparam int DIR_ROWS = 23;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{CMD_QUERY,   10'd0,    12'd0,    1'b1, '{STATUS_STALE, 10'd0, 12'd0, 1'b0, 11'd0}},
    '{CMD_DESTROY, 10'd1023, 12'd4095, 1'b1, '{STATUS_STALE, 10'd0, 12'd0, 1'b0, 11'd0}},
    '{CMD_CREATE,  10'd0,    12'd0,    1'b1, '{STATUS_OK,    10'd0, 12'd0, 1'b0, 11'd1}},
    '{CMD_CREATE,  10'd1023, 12'd4095, 1'b1, '{STATUS_OK,    10'd1, 12'd0, 1'b0, 11'd2}},
    '{CMD_QUERY,   10'd0,    12'd0,    1'b1, '{STATUS_OK,    10'd0, 12'd0, 1'b1, 11'd2}},
    '{CMD_QUERY,   10'd0,    12'd4095, 1'b1, '{STATUS_STALE, 10'd0, 12'd0, 1'b0, 11'd2}},
    '{CMD_DESTROY, 10'd1,    12'd0,    1'b1, '{STATUS_OK,    10'd0, 12'd0, 1'b1, 11'd1}},
    '{CMD_DESTROY, 10'd1,    12'd0,    1'b1, '{STATUS_STALE, 10'd0, 12'd0, 1'b0, 11'd1}},
    '{CMD_QUERY,   10'd1,    12'd1,    1'b1, '{STATUS_STALE, 10'd0, 12'd0, 1'b0, 11'd1}},
    '{CMD_CREATE,  10'd0,    12'd0,    1'b0, '{STATUS_OK,    10'd0, 12'd0, 1'b0, 11'd0}},
    '{CMD_QUERY,   10'd1,    12'd1,    1'b1, '{STATUS_OK,    10'd0, 12'd0, 1'b1, 11'd2}},
    '{CMD_QUERY,   10'd1023, 12'd0,    1'b1, '{STATUS_STALE, 10'd0, 12'd0, 1'b0, 11'd2}},
    '{CMD_DESTROY, 10'd0,    12'd0,    1'b0, '{STATUS_OK,    10'd0, 12'd0, 1'b0, 11'd0}},
    '{CMD_DESTROY, 10'd1,    12'd1,    1'b0, '{STATUS_OK,    10'd0, 12'd0, 1'b0, 11'd0}},
    '{CMD_CREATE,  10'd0,    12'd0,    1'b0, '{STATUS_OK,    10'd0, 12'd0, 1'b0, 11'd0}},
    '{CMD_CREATE,  10'd0,    12'd0,    1'b0, '{STATUS_OK,    10'd0, 12'd0, 1'b0, 11'd0}},
    '{CMD_CREATE,  10'd0,    12'd0,    1'b0, '{STATUS_OK,    10'd0, 12'd0, 1'b0, 11'd0}},
    '{CMD_CLEAR,   10'd1023, 12'd4095, 1'b1, '{STATUS_OK,    10'd0, 12'd0, 1'b0, 11'd0}},
    '{CMD_QUERY,   10'd0,    12'd1,    1'b1, '{STATUS_STALE, 10'd0, 12'd0, 1'b0, 11'd0}},
    '{CMD_CREATE,  10'd0,    12'd0,    1'b1, '{STATUS_OK,    10'd0, 12'd0, 1'b0, 11'd1}},
    '{CMD_DESTROY, 10'd0,    12'd0,    1'b0, '{STATUS_OK,    10'd0, 12'd0, 1'b0, 11'd0}},
    '{CMD_CREATE,  10'd0,    12'd0,    1'b0, '{STATUS_OK,    10'd0, 12'd0, 1'b0, 11'd0}},
    '{CMD_CLEAR,   10'd0,    12'd0,    1'b1, '{STATUS_OK,    10'd0, 12'd0, 1'b0, 11'd0}}
  };

  logic clk;
  logic rst;

  hga_req_if alloc_req ();
  hga_rsp_if alloc_rsp ();

  generational_handle_allocator #(
    .MAX_HANDLES(NUM_SLOTS),
    .GEN_BITS   (HGEN_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(alloc_req),
    .rsp(alloc_rsp)
  );

  // Predicted allocator state.
  bit [HGEN_W-1:0] slot_gen   [NUM_SLOTS];
  bit              slot_live  [NUM_SLOTS];
  bit [HIDX_W-1:0] free_stack [NUM_SLOTS];
  int              stack_depth;
  int              high_mark;

  int              live_pool [$];
  alloc_result_t   pending_results [$];

  int idle_pct;
  int error_count;
  int items_sent;
  int results_checked;
  int capacity_refusals;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d results pending",
               pending_results.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic bit handle_is_live(input logic [HIDX_W-1:0] hi,
                                        input logic [HGEN_W-1:0] hg);
    if (int'(hi) >= high_mark) return 1'b0;
    return slot_live[hi] && (slot_gen[hi] == hg);
  endfunction

  function automatic alloc_result_t allocate_step(input cmd_t c,
                                                  input logic [HIDX_W-1:0] hi,
                                                  input logic [HGEN_W-1:0] hg);
    alloc_result_t r;
    int slot;
    r = '0;
    case (c)
      CMD_CREATE: begin
        slot = -1;
        if (stack_depth > 0) begin
          stack_depth--;
          slot = free_stack[stack_depth];
        end else if (high_mark < NUM_SLOTS) begin
          slot = high_mark;
          high_mark++;
          slot_gen[slot] = '0;
        end
        if (slot >= 0) begin
          slot_live[slot] = 1'b1;
          r.index = HIDX_W'(slot);
          r.generation = slot_gen[slot];
        end else begin
          r.status = STATUS_CAPACITY;
        end
      end
      CMD_DESTROY: begin
        if (handle_is_live(hi, hg)) begin
          slot_live[hi] = 1'b0;
          slot_gen[hi] = slot_gen[hi] + 1'b1;
          free_stack[stack_depth] = hi;
          stack_depth++;
          r.alive = 1'b1;
        end else begin
          r.status = STATUS_STALE;
        end
      end
      CMD_QUERY: begin
        if (handle_is_live(hi, hg)) r.alive = 1'b1;
        else r.status = STATUS_STALE;
      end
      default: begin
        high_mark = 0;
        stack_depth = 0;
      end
    endcase
    r.count = COUNT_W'(high_mark - stack_depth);
    return r;
  endfunction

  function automatic void report_mismatch(input string what, input alloc_result_t want,
                                          input alloc_result_t got);
    error_count++;
    if (error_count <= SHOW_ERRORS) begin
      $display("%0t %s: expected st=%0d idx=%0d gen=%0d alive=%0d cnt=%0d", $realtime,
               what, want.status, want.index, want.generation, want.alive, want.count);
      $display("%0t %s: actual   st=%0d idx=%0d gen=%0d alive=%0d cnt=%0d", $realtime,
               what, got.status, got.index, got.generation, got.alive, got.count);
    end
  endfunction

  // Caller stands at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input cmd_t c, input logic [HIDX_W-1:0] hi,
                           input logic [HGEN_W-1:0] hg, input bit typed,
                           input alloc_result_t typed_want);
    alloc_result_t pred;
    int pos;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      alloc_req.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    alloc_req.valid <= 1'b1;
    alloc_req.cmd <= c;
    alloc_req.handle_index <= hi;
    alloc_req.handle_generation <= hg;
    do @(posedge clk); while (!alloc_req.ready);
    pred = allocate_step(c, hi, hg);
    pending_results = {pending_results, (typed ? typed_want : pred)};
    items_sent++;
    if (pred.status == STATUS_CAPACITY) capacity_refusals++;
    if (c == CMD_CREATE && pred.status == STATUS_OK) begin
      live_pool = {live_pool, int'(pred.index)};
    end else if (c == CMD_DESTROY && pred.alive) begin
      pos = -1;
      foreach (live_pool[k]) if (live_pool[k] == int'(hi)) pos = k;
      if (pos >= 0) live_pool.delete(pos);
    end else if (c == CMD_CLEAR) begin
      live_pool.delete();
    end
    @(negedge clk);
  endtask

  // Weights are percentages; whatever is left over becomes an item with random fields.
  task automatic random_item(input int w_create, input int w_destroy, input int w_query,
                             input int w_stale, input int w_clear);
    cmd_t c;
    logic [HIDX_W-1:0] hi;
    logic [HGEN_W-1:0] hg;
    int roll;
    roll = $urandom_range(99);
    hi = HIDX_W'($urandom);
    hg = HGEN_W'($urandom);
    c = cmd_t'(CMD_W'($urandom_range(w_clear > 0 ? 3 : 2)));
    if (roll < w_create) begin
      c = CMD_CREATE;
    end else if (roll < w_create + w_destroy + w_query) begin
      c = (roll < w_create + w_destroy) ? CMD_DESTROY : CMD_QUERY;
      if (live_pool.size() > 0) begin
        hi = HIDX_W'(live_pool[$urandom_range(live_pool.size() - 1)]);
        hg = slot_gen[hi];
      end
    end else if (roll < w_create + w_destroy + w_query + w_stale) begin
      c = $urandom_range(1) ? CMD_DESTROY : CMD_QUERY;
      // Near misses: a handed-out slot with an old, a future or its current generation.
      if (high_mark > 0 && $urandom_range(3) != 0) begin
        hi = HIDX_W'($urandom_range(high_mark - 1));
        case ($urandom_range(2))
          0: hg = slot_gen[hi] - 1'b1;
          1: hg = slot_gen[hi] + 1'b1;
          default: hg = slot_gen[hi];
        endcase
      end
    end else if (roll < w_create + w_destroy + w_query + w_stale + w_clear) begin
      c = CMD_CLEAR;
    end
    send_item(c, hi, hg, 1'b0, '0);
  endtask

  // Response side: bursts of backpressure while idling is enabled.
  initial begin
    int stall_left;
    stall_left = 0;
    alloc_rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        alloc_rsp.ready <= 1'b0;
      end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
        stall_left = $urandom_range(1, 13) - 1;
        alloc_rsp.ready <= 1'b0;
      end else begin
        alloc_rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (!rst && alloc_rsp.valid && alloc_rsp.ready) begin
      got.status = alloc_rsp.status;
      got.index = alloc_rsp.result_index;
      got.generation = alloc_rsp.result_generation;
      got.alive = alloc_rsp.is_alive;
      got.count = alloc_rsp.live_count;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.status !== want.status || got.index !== want.index ||
            got.generation !== want.generation || got.alive !== want.alive ||
            got.count !== want.count)
          report_mismatch("result mismatch", want, got);
      end
    end
  end

  initial begin
    cycle_count = 0;
    error_count = 0;
    items_sent = 0;
    results_checked = 0;
    capacity_refusals = 0;
    stack_depth = 0;
    high_mark = 0;
    idle_pct = 25;
    rst = 1'b1;
    alloc_req.valid = 1'b0;
    alloc_req.cmd = CMD_CREATE;
    alloc_req.handle_index = '0;
    alloc_req.handle_generation = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int n = 0; n < DIR_ROWS; n++)
      send_item(DIRECTED[n].cmd, DIRECTED[n].index, DIRECTED[n].generation,
                DIRECTED[n].typed, DIRECTED[n].want);

    idle_pct = 30;
    repeat (60) random_item(40, 25, 10, 15, 2);

    // Push the allocator to capacity and keep asking until it has refused several times.
    idle_pct = 15;
    while (capacity_refusals < 6) random_item(97, 1, 1, 1, 0);

    // At full capacity a create succeeds only by reusing the slot freed last.
    idle_pct = 0;
    repeat (40) random_item(35, 35, 15, 15, 0);
    alloc_req.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d requests and checked %0d responses in %0d cycles", items_sent,
             results_checked, cycle_count);
    $display("Capacity refusals seen: %0d; freed slots were reused at full capacity",
             capacity_refusals);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* generational_handle_allocator.f */
+incdir+rtl
rtl/hga_pkg.sv
rtl/hga_req_if.sv
rtl/hga_rsp_if.sv
rtl/hga_ram.sv
rtl/hga_ctrl.sv
rtl/hga_datapath.sv
rtl/generational_handle_allocator.sv
tb/sv/tb_generational_handle_allocator.sv
